// ----- sv/fqa_pkg.sv -----
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies; every other file uses it by scoped names.
`default_nettype none

package fqa_pkg;

   // Data path widths
   localparam int WORD_W        = 32;
   localparam int ACTION_W      = 4;
   localparam int FRAC_BITS_DEF = 8;

   // Operation codes
   typedef enum logic [ACTION_W-1:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_GE       = 4'd6,
      OP_LE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_TO_INT   = 4'd14,
      OP_FROM_INT = 4'd15
   } op_type;

   // Per-item data carried alongside the divider
   typedef struct packed {
      op_type            action;
      logic [WORD_W-1:0] value;     // finished result for every non-divide op
      logic              cmp;       // comparison outcome
      logic              dz;        // divide requested with zero divisor
      logic              neg;       // quotient sign
   } side_type;

   // One result beat
   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              cmp;
      logic              dz;
   } res_type;

endpackage

`default_nettype wire

// ----- sv/fqa_req_if.sv -----
// Request channel: operation code and two raw Q24.8 operands.
// Depends on fqa_pkg for widths.
`default_nettype none

interface fqa_req_if;
   logic                                valid;
   logic                                ready;
   logic [fqa_pkg::ACTION_W-1:0]        action;
   logic signed [fqa_pkg::WORD_W-1:0]   operand_a;
   logic signed [fqa_pkg::WORD_W-1:0]   operand_b;

   modport source (output valid, action, operand_a, operand_b, input ready);
   modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

// ----- sv/fqa_rsp_if.sv -----
// Response channel: result value, compare flag and divide-by-zero flag.
// Depends on fqa_pkg for widths.
`default_nettype none

interface fqa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fqa_pkg::WORD_W-1:0]   value;
   logic                                compare_true;
   logic                                divide_by_zero;

   modport source (output valid, value, compare_true, divide_by_zero, input ready);
   modport sink   (input valid, value, compare_true, divide_by_zero, output ready);
endinterface

`default_nettype wire

// ----- sv/fixed_point_q24_8_alu_top.sv -----
// Top level of the Q24.8 fixed-point ALU.
// Depends on fqa_pkg, fqa_req_if, fqa_rsp_if, fqa_front, fqa_div, fqa_out.
//
//   channel    direction  payload                                   handshake
//   req_chan   in         action, operand_a, operand_b              valid/ready
//   rsp_chan   out        value, compare_true, divide_by_zero       valid/ready
//
// One beat per cycle sustained while rsp_chan accepts. FRAC_BITS + 35 register
// stages (43 at 8): input register, multiply stage, one divider stage per quotient
// bit, output register. The divider's bit-per-stage chain sets the depth.
// Reset clears all valid bits; ready is high once the skid entry is empty.
// When the output blocks, the pipeline keeps moving until a beat lands in the
// skid entry; from then on the whole pipeline and the input hold.
`default_nettype none

module fixed_point_q24_8_alu_top #(
   parameter int FRAC_BITS = fqa_pkg::FRAC_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   fqa_req_if.sink      req_chan,
   fqa_rsp_if.source    rsp_chan
);

   localparam int DW = fqa_pkg::WORD_W + FRAC_BITS;

   logic                        adv;
   logic                        f_valid;
   fqa_pkg::side_type           f_side;
   logic [DW-1:0]               f_nq;
   logic [fqa_pkg::WORD_W-1:0]  f_d;
   logic                        d_valid;
   fqa_pkg::side_type           d_side;
   logic [fqa_pkg::WORD_W-1:0]  d_q;

   assign req_chan.ready = adv;

   // Input capture, non-divide ops and divider setup
   fqa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_chan.valid),
      .in_action (req_chan.action),
      .in_a      (req_chan.operand_a),
      .in_b      (req_chan.operand_b),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_nq    (f_nq),
      .out_d     (f_d)
   );

   // Divider pipeline
   fqa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_side   (f_side),
      .in_nq     (f_nq),
      .in_d      (f_d),
      .out_valid (d_valid),
      .out_side  (d_side),
      .out_q     (d_q)
   );

   // Result select and output buffering
   fqa_out u_out (
      .clock      (clock),
      .reset      (reset),
      .pipe_valid (d_valid),
      .pipe_side  (d_side),
      .pipe_q     (d_q),
      .adv        (adv),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- sv/fqa_front.sv -----
// Front end: input register, then one stage holding the multiplier, the
// simple ops and the divider setup. Depends on fqa_pkg.
`default_nettype none

module fqa_front #(
   parameter int FRAC_BITS = fqa_pkg::FRAC_BITS_DEF,
   localparam int DW       = fqa_pkg::WORD_W + FRAC_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                adv,
   input  wire logic                                in_valid,
   input  wire logic [fqa_pkg::ACTION_W-1:0]        in_action,
   input  wire logic signed [fqa_pkg::WORD_W-1:0]   in_a,
   input  wire logic signed [fqa_pkg::WORD_W-1:0]   in_b,
   output logic                                     out_valid,
   output fqa_pkg::side_type                        out_side,
   output logic [DW-1:0]                            out_nq,
   output logic [fqa_pkg::WORD_W-1:0]               out_d
);

   localparam logic [fqa_pkg::WORD_W-1:0] WORD_ONE = 1;

   // Stage 0: captured beat
   logic                               v0_ff;
   fqa_pkg::op_type                    act0_ff;
   logic signed [fqa_pkg::WORD_W-1:0]  a0_ff;
   logic signed [fqa_pkg::WORD_W-1:0]  b0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
      end
      if (adv) begin
         act0_ff <= fqa_pkg::op_type'(in_action);
         a0_ff   <= in_a;
         b0_ff   <= in_b;
      end
   end

   // Stage 1: arithmetic
   logic signed [2*fqa_pkg::WORD_W-1:0] prod;
   logic                                lt, gt, eq;
   logic [fqa_pkg::WORD_W-1:0]          a_u, b_u, a_mag, b_mag;
   fqa_pkg::side_type                   side_in;
   logic [DW-1:0]                       nq_in;

   assign prod  = a0_ff * b0_ff;
   assign lt    = a0_ff < b0_ff;
   assign gt    = b0_ff < a0_ff;
   assign eq    = a0_ff == b0_ff;
   assign a_u   = a0_ff;
   assign b_u   = b0_ff;
   assign a_mag = a0_ff[fqa_pkg::WORD_W-1] ? (~a_u + WORD_ONE) : a_u;
   assign b_mag = b0_ff[fqa_pkg::WORD_W-1] ? (~b_u + WORD_ONE) : b_u;
   assign nq_in = {a_mag, {FRAC_BITS{1'b0}}};

   always_comb begin
      side_in        = '0;
      side_in.action = act0_ff;
      side_in.neg    = a0_ff[fqa_pkg::WORD_W-1] ^ b0_ff[fqa_pkg::WORD_W-1];
      unique case (act0_ff)
         fqa_pkg::OP_ADD:      side_in.value = a_u + b_u;
         fqa_pkg::OP_SUB:      side_in.value = a_u - b_u;
         fqa_pkg::OP_MUL:      side_in.value = prod[FRAC_BITS+fqa_pkg::WORD_W-1:FRAC_BITS];
         fqa_pkg::OP_DIV:      side_in.dz    = (b_u == '0);
         fqa_pkg::OP_GT:       side_in.cmp   = gt;
         fqa_pkg::OP_LT:       side_in.cmp   = lt;
         fqa_pkg::OP_GE:       side_in.cmp   = !lt;
         fqa_pkg::OP_LE:       side_in.cmp   = !gt;
         fqa_pkg::OP_EQ:       side_in.cmp   = eq;
         fqa_pkg::OP_NE:       side_in.cmp   = !eq;
         fqa_pkg::OP_MIN:      side_in.value = lt ? a_u : b_u;
         fqa_pkg::OP_MAX:      side_in.value = gt ? a_u : b_u;
         fqa_pkg::OP_INC:      side_in.value = a_u + WORD_ONE;
         fqa_pkg::OP_DEC:      side_in.value = a_u - WORD_ONE;
         fqa_pkg::OP_TO_INT:   side_in.value = a0_ff >>> FRAC_BITS;
         fqa_pkg::OP_FROM_INT: side_in.value = a_u << FRAC_BITS;
         default:              side_in.value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (adv) begin
         out_valid <= v0_ff;
      end
      if (adv) begin
         out_side <= side_in;
         out_nq   <= nq_in;
         out_d    <= b_mag;
      end
   end

endmodule

`default_nettype wire

// ----- sv/fqa_div.sv -----
// Restoring divider on magnitudes, one quotient bit per register stage;
// carries the other ops' results alongside. Depends on fqa_pkg.
`default_nettype none

module fqa_div #(
   parameter int FRAC_BITS = fqa_pkg::FRAC_BITS_DEF,
   localparam int DW       = fqa_pkg::WORD_W + FRAC_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire logic                         in_valid,
   input  wire fqa_pkg::side_type            in_side,
   input  wire logic [DW-1:0]                in_nq,
   input  wire logic [fqa_pkg::WORD_W-1:0]   in_d,
   output logic                              out_valid,
   output fqa_pkg::side_type                 out_side,
   output logic [fqa_pkg::WORD_W-1:0]        out_q
);

   localparam int W = fqa_pkg::WORD_W;

   // Stage k holds the state after quotient step k; stage 1 takes the inputs
   for (genvar k = 1; k <= DW; k++) begin : g_step
      logic              v_ff;
      fqa_pkg::side_type side_ff;
      logic [DW-1:0]     nq_ff;   // dividend bits shift out, quotient bits in
      logic [W-1:0]      r_ff;    // partial remainder
      logic [W-1:0]      d_ff;    // divisor magnitude
      logic              v_prev;
      fqa_pkg::side_type side_prev;
      logic [DW-1:0]     nq_prev;
      logic [W-1:0]      r_prev;
      logic [W-1:0]      d_prev;
      logic [W:0]        trial;
      logic [W:0]        diff;
      logic              ge;
      logic [W-1:0]      r_in;
      logic [DW-1:0]     nq_in;

      if (k == 1) begin : g_head
         assign v_prev    = in_valid;
         assign side_prev = in_side;
         assign nq_prev   = in_nq;
         assign r_prev    = '0;
         assign d_prev    = in_d;
      end else begin : g_body
         assign v_prev    = g_step[k-1].v_ff;
         assign side_prev = g_step[k-1].side_ff;
         assign nq_prev   = g_step[k-1].nq_ff;
         assign r_prev    = g_step[k-1].r_ff;
         assign d_prev    = g_step[k-1].d_ff;
      end

      // shift in the next dividend bit, subtract when it fits
      assign trial = {r_prev, nq_prev[DW-1]};
      assign diff  = trial - {1'b0, d_prev};
      assign ge    = trial >= {1'b0, d_prev};
      assign r_in  = ge ? diff[W-1:0] : trial[W-1:0];
      assign nq_in = {nq_prev[DW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= v_prev;
         end
         if (adv) begin
            side_ff <= side_prev;
            nq_ff   <= nq_in;
            r_ff    <= r_in;
            d_ff    <= d_prev;
         end
      end
   end

   assign out_valid = g_step[DW].v_ff;
   assign out_side  = g_step[DW].side_ff;
   assign out_q     = g_step[DW].nq_ff[W-1:0];

endmodule

`default_nettype wire

// ----- sv/fqa_out.sv -----
// Result select, output register and skid stage; produces the pipeline
// advance. Depends on fqa_pkg and fqa_rsp_if.
`default_nettype none

module fqa_out (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         pipe_valid,
   input  wire fqa_pkg::side_type            pipe_side,
   input  wire logic [fqa_pkg::WORD_W-1:0]   pipe_q,
   output logic                              adv,
   fqa_rsp_if.source                         rsp_chan
);

   // Final result: zero on divide by zero, signed quotient for divide, carried value otherwise
   fqa_pkg::res_type res_new;

   always_comb begin
      res_new.cmp = pipe_side.cmp;
      res_new.dz  = pipe_side.dz;
      if (pipe_side.dz) begin
         res_new.value = '0;
      end else if (pipe_side.action == fqa_pkg::OP_DIV) begin
         res_new.value = pipe_side.neg ? (-pipe_q) : pipe_q;
      end else begin
         res_new.value = pipe_side.value;
      end
   end

   // Output register plus one skid entry
   logic             out_v_ff, out_v_in;
   fqa_pkg::res_type out_ff, out_in;
   logic             skid_v_ff, skid_v_in;
   fqa_pkg::res_type skid_ff, skid_in;
   logic             out_load, pipe_take;

   assign adv       = !skid_v_ff;
   assign out_load  = !out_v_ff || rsp_chan.ready;
   assign pipe_take = pipe_valid && adv;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (out_load) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in  = pipe_take;
            out_in    = res_new;
         end
      end else if (pipe_take) begin
         skid_v_in = 1'b1;
         skid_in   = res_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid          = out_v_ff;
   assign rsp_chan.value          = out_ff.value;
   assign rsp_chan.compare_true   = out_ff.cmp;
   assign rsp_chan.divide_by_zero = out_ff.dz;

endmodule

`default_nettype wire
